@@ sv/pbd_pkg.sv @@
// Shared types, constants and register map of the planar PackBits row decoder.
`default_nettype none

package pbd_pkg;

    // Default limits of the top-level parameters
    localparam int PBD_MAX_ROW_BYTES = 256;
    localparam int PBD_MAX_ROWS      = 1024;
    localparam int PBD_MAX_PLANES    = 8;

    // Result queue between decoder and output stage
    localparam int PBD_QDEPTH = 4;

    // Configuration port
    localparam int PBD_AW = 5;
    localparam int PBD_DW = 32;

    localparam logic [2:0] REG_ROW_BYTES   = 3'd0;
    localparam logic [2:0] REG_ROW_COUNT   = 3'd1;
    localparam logic [2:0] REG_PLANE_COUNT = 3'd2;
    localparam logic [2:0] REG_COMPRESSED  = 3'd3;
    localparam logic [2:0] REG_START_X     = 3'd4;
    localparam logic [2:0] REG_START_Y     = 3'd5;

    localparam logic [8:0]  RST_ROW_BYTES   = 9'd1;
    localparam logic [10:0] RST_ROW_COUNT   = 11'd1;
    localparam logic [3:0]  RST_PLANE_COUNT = 4'd1;
    localparam logic        RST_COMPRESSED  = 1'b1;
    localparam logic [11:0] RST_START_X     = 12'd0;
    localparam logic [11:0] RST_START_Y     = 12'd0;

    // Header byte that consumes one row byte and writes nothing
    localparam logic [7:0] HDR_NOP = 8'h80;

    typedef struct packed {
        logic [8:0]  row_bytes;
        logic [10:0] row_count;
        logic [3:0]  plane_count;
        logic        compressed;
        logic [11:0] start_x;
        logic [11:0] start_y;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  value;
        logic [7:0]  repeat_res;
        logic [2:0]  plane;
        logic [12:0] row;
        logic [9:0]  column;
        logic        shape_done;
        logic        overrun;
    } t_res;

endpackage

`default_nettype wire

@@ sv/pbd_in_if.sv @@
// Input byte channel of the decoder.
`default_nettype none

interface pbd_in_if
    import pbd_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;

    modport source (output valid, output src_byte, input ready);
    modport sink   (input valid, input src_byte, output ready);
endinterface

`default_nettype wire

@@ sv/pbd_out_if.sv @@
// Result channel of the decoder.
`default_nettype none

interface pbd_out_if
    import pbd_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [7:0]  value;
    logic [7:0]  repeat_res;
    logic [2:0]  plane;
    logic [12:0] row;
    logic [9:0]  column;
    logic        shape_done;
    logic        overrun;

    modport source (output valid, output value, output repeat_res, output plane, output row,
                    output column, output shape_done, output overrun, input ready);
    modport sink   (input valid, input value, input repeat_res, input plane, input row,
                    input column, input shape_done, input overrun, output ready);
endinterface

`default_nettype wire

@@ sv/pbd_regs.sv @@
// APB-style configuration registers with a restart strobe on every write to one of the six defined registers.
`default_nettype none

module pbd_regs
    import pbd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [PBD_AW-1:0] paddr,
    input  wire logic [PBD_DW-1:0] pwdata,
    output logic      [PBD_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg,
    output logic                   o_restart
);

    t_cfg       r_cfg;
    logic       wr;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_bytes   <= RST_ROW_BYTES;
            r_cfg.row_count   <= RST_ROW_COUNT;
            r_cfg.plane_count <= RST_PLANE_COUNT;
            r_cfg.compressed  <= RST_COMPRESSED;
            r_cfg.start_x     <= RST_START_X;
            r_cfg.start_y     <= RST_START_Y;
        end else if (wr) begin
            unique case (idx)
                REG_ROW_BYTES:   r_cfg.row_bytes   <= pwdata[8:0];
                REG_ROW_COUNT:   r_cfg.row_count   <= pwdata[10:0];
                REG_PLANE_COUNT: r_cfg.plane_count <= pwdata[3:0];
                REG_COMPRESSED:  r_cfg.compressed  <= pwdata[0];
                REG_START_X:     r_cfg.start_x     <= pwdata[11:0];
                REG_START_Y:     r_cfg.start_y     <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_restart = 1'b0;
        prdata    = '0;
        unique case (idx)
            REG_ROW_BYTES: begin
                o_restart = wr;
                prdata    = PBD_DW'(r_cfg.row_bytes);
            end
            REG_ROW_COUNT: begin
                o_restart = wr;
                prdata    = PBD_DW'(r_cfg.row_count);
            end
            REG_PLANE_COUNT: begin
                o_restart = wr;
                prdata    = PBD_DW'(r_cfg.plane_count);
            end
            REG_COMPRESSED: begin
                o_restart = wr;
                prdata    = PBD_DW'(r_cfg.compressed);
            end
            REG_START_X: begin
                o_restart = wr;
                prdata    = PBD_DW'(r_cfg.start_x);
            end
            REG_START_Y: begin
                o_restart = wr;
                prdata    = PBD_DW'(r_cfg.start_y);
            end
            default: ;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ sv/pbd_front.sv @@
// Decoder front end: takes source bytes, tracks header/run/literal/pad and row position.
`default_nettype none

module pbd_front
    import pbd_pkg::*;
#(
    parameter int MAX_ROW_BYTES = PBD_MAX_ROW_BYTES,
    parameter int MAX_ROWS      = PBD_MAX_ROWS,
    parameter int MAX_PLANES    = PBD_MAX_PLANES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_restart,
    pbd_in_if.sink    i_in,
    input  wire logic i_full,
    output logic      o_push,
    output t_res      o_res
);

    localparam int LW = $clog2(MAX_ROW_BYTES + 2);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int KW = (LW > 9) ? LW : 9;

    typedef enum logic [1:0] {PH_HDR, PH_RUN, PH_LIT, PH_PAD} t_phase;

    t_phase        r_phase, n_phase;
    logic [7:0]    r_count_left, n_count_left;
    logic [LW-1:0] r_used, n_used;
    logic [2:0]    r_plane, n_plane;
    logic [RW-1:0] r_row, n_row;
    logic [LW-1:0] r_col, n_col;
    logic          r_skip_pad, n_skip_pad;
    logic          r_ovf_hold, n_ovf_hold;

    logic [31:0]   rb32, rc32;
    logic [LW-1:0] eff_rb, padded, left, n_left, left_after;
    logic [RW-1:0] eff_rows;
    logic [3:0]    eff_planes;
    logic          odd;
    logic          accept;

    logic [7:0]    b;
    logic [8:0]    cnt_raw;
    logic [KW-1:0] cnt_w, left_w, cnt_cl;
    logic          ovf_n, sp;
    logic [7:0]    cnt_f, cl_dec;

    logic          emit, ovf, done;
    logic [7:0]    val, rep;

    // Effective geometry: zero counts as one, large values saturate
    always_comb begin
        rb32 = 32'(i_cfg.row_bytes);
        rc32 = 32'(i_cfg.row_count);
        if (rb32 == 32'd0) begin
            eff_rb = LW'(1);
        end else if (rb32 > 32'(MAX_ROW_BYTES)) begin
            eff_rb = LW'(MAX_ROW_BYTES);
        end else begin
            eff_rb = LW'(rb32);
        end
        if (rc32 == 32'd0) begin
            eff_rows = RW'(1);
        end else if (rc32 > 32'(MAX_ROWS)) begin
            eff_rows = RW'(MAX_ROWS);
        end else begin
            eff_rows = RW'(rc32);
        end
        if (i_cfg.plane_count == 4'd0) begin
            eff_planes = 4'd1;
        end else if (32'(i_cfg.plane_count) > 32'(MAX_PLANES)) begin
            eff_planes = 4'(MAX_PLANES);
        end else begin
            eff_planes = i_cfg.plane_count;
        end
    end

    assign odd    = eff_rb[0];
    assign padded = eff_rb + LW'(odd);
    // bytes consumed are kept, so a restart needs no geometry
    assign left   = padded - r_used;

    assign accept      = i_in.valid && !i_full;
    assign i_in.ready  = !i_full;
    assign b           = i_in.src_byte;

    // header count and clamp
    always_comb begin
        cnt_raw    = b[7] ? (9'd257 - {1'b0, b}) : ({1'b0, b} + 9'd1);
        cnt_w      = KW'(cnt_raw);
        left_w     = KW'(left);
        ovf_n      = cnt_w > left_w;
        cnt_cl     = ovf_n ? left_w : cnt_w;
        left_after = left - LW'(cnt_cl);
    end

    always_comb begin
        n_phase      = r_phase;
        n_count_left = r_count_left;
        n_left       = left;
        n_plane      = r_plane;
        n_row        = r_row;
        n_col        = r_col;
        n_skip_pad   = r_skip_pad;
        n_ovf_hold   = r_ovf_hold;
        emit         = 1'b0;
        ovf          = 1'b0;
        done         = 1'b0;
        val          = 8'd0;
        rep          = 8'd0;
        sp           = 1'b0;
        cnt_f        = 8'd0;
        cl_dec       = 8'd0;

        unique case (r_phase)
            PH_HDR: begin
                if (!i_cfg.compressed) begin
                    if (odd && left == LW'(1)) begin
                        n_left = '0;
                    end else begin
                        emit = 1'b1;
                        val  = b;
                        rep  = 8'd1;
                        if (left != '0) n_left = left - LW'(1);
                        n_col = r_col + LW'(1);
                    end
                end else if (b == HDR_NOP) begin
                    if (left != '0) n_left = left - LW'(1);
                end else begin
                    n_ovf_hold = ovf_n;
                    n_left     = left_after;
                    if (b[7]) begin
                        cnt_f = cnt_cl[7:0] -
                                8'(left_after == '0 && odd && cnt_cl != '0);
                        n_count_left = cnt_f;
                        n_phase      = PH_RUN;
                    end else begin
                        sp           = left_after == '0 && odd;
                        cnt_f        = cnt_cl[7:0] - 8'(sp && cnt_cl != '0);
                        n_skip_pad   = sp;
                        n_count_left = cnt_f;
                        n_phase      = (cnt_f != 8'd0) ? PH_LIT : (sp ? PH_PAD : PH_HDR);
                    end
                end
            end
            PH_RUN: begin
                val          = b;
                rep          = r_count_left;
                ovf          = r_ovf_hold;
                emit         = r_count_left != 8'd0;
                n_col        = r_col + LW'(r_count_left);
                n_count_left = 8'd0;
                n_phase      = PH_HDR;
            end
            PH_LIT: begin
                val          = b;
                rep          = 8'd1;
                ovf          = r_ovf_hold;
                emit         = 1'b1;
                n_col        = r_col + LW'(1);
                cl_dec       = (r_count_left != 8'd0) ? r_count_left - 8'd1 : 8'd0;
                n_count_left = cl_dec;
                if (cl_dec == 8'd0) n_phase = r_skip_pad ? PH_PAD : PH_HDR;
            end
            PH_PAD: begin
                n_skip_pad = 1'b0;
                n_phase    = PH_HDR;
            end
            default: ;
        endcase

        // end of a plane row
        if (n_phase == PH_HDR && n_left == '0) begin
            n_col  = '0;
            n_left = padded;
            if ({1'b0, r_plane} + 4'd1 >= eff_planes) begin
                n_plane = 3'd0;
                if (r_row + RW'(1) >= eff_rows) begin
                    done         = 1'b1;
                    n_row        = '0;
                    n_count_left = 8'd0;
                    n_skip_pad   = 1'b0;
                    n_ovf_hold   = 1'b0;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_plane = r_plane + 3'd1;
            end
        end

        n_used = padded - n_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_phase      <= PH_HDR;
            r_count_left <= 8'd0;
            r_used       <= '0;
            r_plane      <= 3'd0;
            r_row        <= '0;
            r_col        <= '0;
            r_skip_pad   <= 1'b0;
            r_ovf_hold   <= 1'b0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_count_left <= n_count_left;
            r_used       <= n_used;
            r_plane      <= n_plane;
            r_row        <= n_row;
            r_col        <= n_col;
            r_skip_pad   <= n_skip_pad;
            r_ovf_hold   <= n_ovf_hold;
        end
    end

    assign o_push           = accept && (emit || done);
    assign o_res.value      = emit ? val : 8'd0;
    assign o_res.repeat_res = emit ? rep : 8'd0;
    assign o_res.plane      = r_plane;
    assign o_res.row        = 13'(i_cfg.start_y) + 13'(r_row);
    assign o_res.column     = 10'(i_cfg.start_x[11:3]) + 10'(r_col);
    assign o_res.shape_done = done;
    assign o_res.overrun    = ovf;

endmodule

`default_nettype wire

@@ sv/pbd_queue.sv @@
// Short result queue between the decoder front end and the output stage.
`default_nettype none

module pbd_queue
    import pbd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_res i_data,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_res      o_data
);

    localparam int QAW = (PBD_QDEPTH > 1) ? $clog2(PBD_QDEPTH) : 1;
    localparam int QCW = $clog2(PBD_QDEPTH + 1);

    t_res           r_mem [PBD_QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;
    logic           do_push, do_pop;

    assign o_full  = r_cnt == QCW'(PBD_QDEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == QAW'(PBD_QDEPTH - 1)) ? '0 : r_wp + QAW'(1);
            if (do_pop)  r_rp <= (r_rp == QAW'(PBD_QDEPTH - 1)) ? '0 : r_rp + QAW'(1);
            r_cnt <= r_cnt + QCW'(do_push) - QCW'(do_pop);
        end
    end

endmodule

`default_nettype wire

@@ sv/pbd_back.sv @@
// Output stage: pulls results from the queue into the registered result channel.
`default_nettype none

module pbd_back
    import pbd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire t_res i_data,
    output logic      o_pop,
    pbd_out_if.source o_out
);

    logic r_valid;
    t_res r_data;

    assign o_pop = !i_empty && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_data <= i_data;
    end

    assign o_out.valid      = r_valid;
    assign o_out.value      = r_data.value;
    assign o_out.repeat_res = r_data.repeat_res;
    assign o_out.plane      = r_data.plane;
    assign o_out.row        = r_data.row;
    assign o_out.column     = r_data.column;
    assign o_out.shape_done = r_data.shape_done;
    assign o_out.overrun    = r_data.overrun;

endmodule

`default_nettype wire

@@ sv/packbits_planar_row_decoder.sv @@
// Top level of the planar PackBits row decoder.
//
//   channel   direction  handshake        payload
//   i_in      in         valid/ready      src_byte
//   o_out     out        valid/ready      value, repeat_res, plane, row, column,
//                                         shape_done, overrun
//   apb       in/out     psel/penable     paddr, pwdata, prdata (pready always 1)
//
// One source byte per cycle while the queue is not full; the front end's state update sets this rate.
// A result passes through a 4-entry queue and then the output register to reach o_out.
// i_in.ready drops only while the queue is full; the front and output stage stall apart.
// Synchronous active-low reset; no clearing pass. A write to a defined register restarts the shape.
`default_nettype none

module packbits_planar_row_decoder
    import pbd_pkg::*;
#(
    parameter int MAX_ROW_BYTES = PBD_MAX_ROW_BYTES,
    parameter int MAX_ROWS      = PBD_MAX_ROWS,
    parameter int MAX_PLANES    = PBD_MAX_PLANES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    pbd_in_if.sink                 i_in,
    pbd_out_if.source              o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [PBD_AW-1:0] paddr,
    input  wire logic [PBD_DW-1:0] pwdata,
    output logic      [PBD_DW-1:0] prdata,
    output logic                   pready
);

    t_cfg cfg;
    logic restart;
    logic push, pop, full, empty;
    t_res front_res, queue_res;

    pbd_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_restart (restart)
    );

    pbd_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS),
        .MAX_PLANES    (MAX_PLANES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_restart (restart),
        .i_in      (i_in),
        .i_full    (full),
        .o_push    (push),
        .o_res     (front_res)
    );

    pbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_res),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (queue_res)
    );

    pbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_data  (queue_res),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
